@@ sv/qfrm_pkg.sv @@
package qfrm_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;

   // trace and radicand
   localparam int SUM_W  = DATA_WIDTH + 2;
   localparam int R_W    = DATA_WIDTH + 4;
   // square root cells: one root bit per cell
   localparam int ROOT_W = (DATA_WIDTH + FRAC_BITS + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   // reciprocal cells: one quotient bit per cell
   localparam int QUO_W  = FRAC_BITS;
   localparam int DREM_W = ROOT_W + 1;
   // off-diagonal pair sums and products
   localparam int D_W    = DATA_WIDTH + 1;
   localparam int P_W    = D_W + QUO_W + 1;
   localparam int SH_W   = P_W - FRAC_BITS;

   localparam logic [DREM_W-1:0] DIV_SEED = DREM_W'(64'd1 << (FRAC_BITS - 2));
   localparam logic [R_W-1:0]    ONE_R    = R_W'(64'd1 << FRAC_BITS);
   localparam logic [P_W-1:0]    HALF_P   = P_W'(64'd1 << (FRAC_BITS - 1));

   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

   localparam logic [1:0] SEL_TRACE = 2'd0;
   localparam logic [1:0] SEL_A00   = 2'd1;
   localparam logic [1:0] SEL_A11   = 2'd2;
   localparam logic [1:0] SEL_A22   = 2'd3;

   typedef struct packed {
      logic [1:0]                sel;
      logic [3:0][D_W-1:0]       d;
   } qfrm_pass_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } qfrm_sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic [DREM_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } qfrm_div_type;

   function automatic logic [DATA_WIDTH-1:0] qfrm_sat(input logic signed [SH_W-1:0] v);
      logic signed [SH_W-1:0] t;
      t = v;
      if (t > SAT_HI) t = SAT_HI;
      if (t < SAT_LO) t = SAT_LO;
      return t[DATA_WIDTH-1:0];
   endfunction

endpackage

@@ sv/qfrm_sqrt_cell.sv @@
module qfrm_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  qfrm_pkg::qfrm_pass_type in_pass,
   input  qfrm_pkg::qfrm_sqrt_type in_st,
   output logic                    out_valid,
   output qfrm_pkg::qfrm_pass_type out_pass,
   output qfrm_pkg::qfrm_sqrt_type out_st
);
   import qfrm_pkg::*;

   logic          valid_ff;
   qfrm_pass_type pass_ff;
   qfrm_sqrt_type st_ff, st_in;
   logic [REM_W-1:0] rem_sh, trial;

   always_comb begin
      rem_sh = {in_st.rem[ROOT_W:0], in_st.rad[RAD_W-1 -: 2]};
      trial  = REM_W'({in_st.root, 2'b01});
      st_in.rad = {in_st.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         st_in.rem  = rem_sh - trial;
         st_in.root = {in_st.root[ROOT_W-2:0], 1'b1};
      end else begin
         st_in.rem  = rem_sh;
         st_in.root = {in_st.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      pass_ff <= in_pass;
      st_ff   <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_pass  = pass_ff;
   assign out_st    = st_ff;
endmodule

@@ sv/qfrm_div_cell.sv @@
module qfrm_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  qfrm_pkg::qfrm_pass_type in_pass,
   input  qfrm_pkg::qfrm_div_type  in_st,
   output logic                    out_valid,
   output qfrm_pkg::qfrm_pass_type out_pass,
   output qfrm_pkg::qfrm_div_type  out_st
);
   import qfrm_pkg::*;

   logic          valid_ff;
   qfrm_pass_type pass_ff;
   qfrm_div_type  st_ff, st_in;
   logic [DREM_W:0] rem_sh, divisor;

   always_comb begin
      rem_sh     = {in_st.rem, 1'b0};
      divisor    = (DREM_W + 1)'(in_st.root);
      st_in.root = in_st.root;
      if (rem_sh >= divisor) begin
         st_in.rem = DREM_W'(rem_sh - divisor);
         st_in.quo = {in_st.quo[QUO_W-2:0], 1'b1};
      end else begin
         st_in.rem = DREM_W'(rem_sh);
         st_in.quo = {in_st.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      pass_ff <= in_pass;
      st_ff   <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_pass  = pass_ff;
   assign out_st    = st_ff;
endmodule

@@ sv/quaternion_from_rotation_matrix_core.sv @@
// An accepted start reaches rsp_valid via input, cell, product and output registers.
// Throughput: one matrix per cycle; busy stays low, so start may be held high.
// The chains hold 15 square-root cells and 14 reciprocal cells, one bit each.
// Reset (synchronous, active high) drops every beat in flight; rsp_valid low.
// The receiver cannot stall: each result is shown for one cycle only.
module quaternion_from_rotation_matrix_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a00,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a01,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a02,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a10,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a11,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a12,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a20,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a21,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0]    req_a22,
   output logic                                      rsp_valid,
   output logic signed [qfrm_pkg::DATA_WIDTH-1:0]    rsp_quat_x,
   output logic signed [qfrm_pkg::DATA_WIDTH-1:0]    rsp_quat_y,
   output logic signed [qfrm_pkg::DATA_WIDTH-1:0]    rsp_quat_z,
   output logic signed [qfrm_pkg::DATA_WIDTH-1:0]    rsp_quat_w
);
   import qfrm_pkg::*;

   assign busy = 1'b0;

   // ---------------- pick and radicand ----------------
   logic signed [SUM_W-1:0] a00_e, a11_e, a22_e, tr, best;
   logic signed [R_W-1:0]   r;
   logic signed [D_W-1:0]   d_12m21, d_20m02, d_01m10, d_01p10, d_20p02, d_12p21;
   logic [1:0]              sel;
   qfrm_pass_type           pass0_in, pass0_ff;
   qfrm_sqrt_type           sq0_in, sq0_ff;
   logic                    v0_ff;

   always_comb begin
      a00_e = SUM_W'(req_a00);
      a11_e = SUM_W'(req_a11);
      a22_e = SUM_W'(req_a22);
      tr    = a00_e + a11_e + a22_e;
      best  = tr;
      sel   = SEL_TRACE;
      if (a00_e > best) begin sel = SEL_A00; best = a00_e; end
      if (a11_e > best) begin sel = SEL_A11; best = a11_e; end
      if (a22_e > best) begin sel = SEL_A22; best = a22_e; end
      if (sel == SEL_TRACE) r = $signed(ONE_R) + R_W'(tr);
      else                  r = $signed(ONE_R) + (R_W'(best) <<< 1) - R_W'(tr);
      if (r < $signed(ONE_R)) r = $signed(ONE_R);

      d_12m21 = D_W'(req_a12) - D_W'(req_a21);
      d_20m02 = D_W'(req_a20) - D_W'(req_a02);
      d_01m10 = D_W'(req_a01) - D_W'(req_a10);
      d_01p10 = D_W'(req_a01) + D_W'(req_a10);
      d_20p02 = D_W'(req_a20) + D_W'(req_a02);
      d_12p21 = D_W'(req_a12) + D_W'(req_a21);

      pass0_in.sel = sel;
      unique case (sel)
         SEL_TRACE: pass0_in.d = {D_W'(0), d_01m10, d_20m02, d_12m21};
         SEL_A00:   pass0_in.d = {d_12m21, d_20p02, d_01p10, D_W'(0)};
         SEL_A11:   pass0_in.d = {d_20m02, d_12p21, D_W'(0), d_01p10};
         SEL_A22:   pass0_in.d = {d_01m10, D_W'(0), d_12p21, d_20p02};
         default:   pass0_in.d = '0;
      endcase

      sq0_in.rad  = RAD_W'($unsigned(r)) << (FRAC_BITS - 2);
      sq0_in.rem  = '0;
      sq0_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start & ~busy;
      pass0_ff <= pass0_in;
      sq0_ff   <= sq0_in;
   end

   // ---------------- square root chain ----------------
   logic          sv [0:ROOT_W];
   qfrm_pass_type sp [0:ROOT_W];
   qfrm_sqrt_type ss [0:ROOT_W];

   assign sv[0] = v0_ff;
   assign sp[0] = pass0_ff;
   assign ss[0] = sq0_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      qfrm_sqrt_cell u_cell (
         .clock(clock), .reset(reset),
         .in_valid(sv[i]), .in_pass(sp[i]), .in_st(ss[i]),
         .out_valid(sv[i+1]), .out_pass(sp[i+1]), .out_st(ss[i+1])
      );
   end

   // ---------------- reciprocal chain ----------------
   logic          dv [0:QUO_W];
   qfrm_pass_type dp [0:QUO_W];
   qfrm_div_type  ds [0:QUO_W];

   assign dv[0]      = sv[ROOT_W];
   assign dp[0]      = sp[ROOT_W];
   assign ds[0].root = ss[ROOT_W].root;
   assign ds[0].rem  = DIV_SEED;
   assign ds[0].quo  = '0;

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      qfrm_div_cell u_cell (
         .clock(clock), .reset(reset),
         .in_valid(dv[i]), .in_pass(dp[i]), .in_st(ds[i]),
         .out_valid(dv[i+1]), .out_pass(dp[i+1]), .out_st(ds[i+1])
      );
   end

   // ---------------- products ----------------
   logic signed [QUO_W:0]           q_s;
   logic signed [P_W-1:0]           prod_in [4];
   logic signed [P_W-1:0]           prod_ff [4];
   logic [DATA_WIDTH-1:0]           sroot_in, sroot_ff;
   logic [1:0]                      sel_ff;
   logic                            vp_ff;

   always_comb begin
      q_s = $signed({1'b0, ds[QUO_W].quo});
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = $signed(dp[QUO_W].d[k]) * q_s;
      end
      sroot_in = qfrm_sat($signed(SH_W'({1'b0, ds[QUO_W].root})));
   end

   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else       vp_ff <= dv[QUO_W];
      prod_ff  <= prod_in;
      sroot_ff <= sroot_in;
      sel_ff   <= dp[QUO_W].sel;
   end

   // ---------------- round, saturate, place s ----------------
   logic signed [P_W-1:0]  rnd   [4];
   logic [DATA_WIDTH-1:0]  comp  [4];
   logic [DATA_WIDTH-1:0]  quat_in [4];
   logic [DATA_WIDTH-1:0]  quat_ff [4];
   logic                   vo_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rnd[k]     = prod_ff[k] + $signed(HALF_P);
         comp[k]    = qfrm_sat($signed(rnd[k][P_W-1:FRAC_BITS]));
         quat_in[k] = comp[k];
      end
      unique case (sel_ff)
         SEL_TRACE: quat_in[3] = sroot_ff;
         SEL_A00:   quat_in[0] = sroot_ff;
         SEL_A11:   quat_in[1] = sroot_ff;
         SEL_A22:   quat_in[2] = sroot_ff;
         default:   quat_in[3] = sroot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= vp_ff;
      quat_ff <= quat_in;
   end

   assign rsp_valid  = vo_ff;
   assign rsp_quat_x = $signed(quat_ff[0]);
   assign rsp_quat_y = $signed(quat_ff[1]);
   assign rsp_quat_z = $signed(quat_ff[2]);
   assign rsp_quat_w = $signed(quat_ff[3]);
endmodule

@@ sv/qfrm_checker.sv @@
module qfrm_port_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic signed [qfrm_pkg::DATA_WIDTH-1:0] rsp_quat_x,
   input logic signed [qfrm_pkg::DATA_WIDTH-1:0] rsp_quat_y,
   input logic signed [qfrm_pkg::DATA_WIDTH-1:0] rsp_quat_z,
   input logic signed [qfrm_pkg::DATA_WIDTH-1:0] rsp_quat_w
);
   import qfrm_pkg::*;

   localparam logic signed [DATA_WIDTH-1:0] HALF_Q =
      DATA_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##32 rsp_valid)
      else $error("accepted beat produced no result");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##32 !rsp_valid)
      else $error("result without accepted beat");

   a_root_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_x >= HALF_Q || rsp_quat_y >= HALF_Q ||
                     rsp_quat_z >= HALF_Q || rsp_quat_w >= HALF_Q))
      else $error("no component at or above one half");
endmodule

bind quaternion_from_rotation_matrix_core qfrm_port_checker u_qfrm_checker (.*);

@@ tb/qfrm_checker.sv @@
`timescale 1ns / 100ps
module qfrm_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0] a00, a01, a02,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0] a10, a11, a12,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0] a20, a21, a22,
   input  logic                                   rsp_valid,
   input  logic signed [qfrm_pkg::DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w,
   output int                                     fail_count,
   output int                                     pending
);
   import qfrm_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef struct packed {
      elem_type x;
      elem_type y;
      elem_type z;
      elem_type w;
   } quat_type;

   quat_type quat_queue[$];

   function automatic elem_type clamp_q(input longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return elem_type'(v);
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r = r + (64'sd1 <<< b);
      return r;
   endfunction

   // round half up: floor of (p + half) / 2^FRAC_BITS
   function automatic elem_type scale_q(input longint d, input longint q);
      return clamp_q((d * q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
   endfunction

   function automatic quat_type matrix_to_quat(input longint m00, m01, m02, m10, m11,
                                               m12, m20, m21, m22);
      longint tr, top, r, s, q;
      logic [1:0] pick;
      quat_type res;
      tr   = m00 + m11 + m22;
      top  = tr;
      pick = SEL_TRACE;
      if (m00 > top) begin pick = SEL_A00; top = m00; end
      if (m11 > top) begin pick = SEL_A11; top = m11; end
      if (m22 > top) begin pick = SEL_A22; top = m22; end
      r = (pick == SEL_TRACE) ? (64'sd1 <<< FRAC_BITS) + tr
                              : (64'sd1 <<< FRAC_BITS) + 2 * top - tr;
      if (r < (64'sd1 <<< FRAC_BITS)) r = 64'sd1 <<< FRAC_BITS;
      s = int_sqrt(r <<< (FRAC_BITS - 2));
      if (s == 0) s = 1;
      q = (64'sd1 <<< (2 * FRAC_BITS - 2)) / s;
      case (pick)
         SEL_TRACE: begin
            res.x = scale_q(m12 - m21, q); res.y = scale_q(m20 - m02, q);
            res.z = scale_q(m01 - m10, q); res.w = clamp_q(s);
         end
         SEL_A00: begin
            res.x = clamp_q(s);            res.y = scale_q(m01 + m10, q);
            res.z = scale_q(m20 + m02, q); res.w = scale_q(m12 - m21, q);
         end
         SEL_A11: begin
            res.x = scale_q(m01 + m10, q); res.y = clamp_q(s);
            res.z = scale_q(m12 + m21, q); res.w = scale_q(m20 - m02, q);
         end
         default: begin
            res.x = scale_q(m20 + m02, q); res.y = scale_q(m12 + m21, q);
            res.z = clamp_q(s);            res.w = scale_q(m01 - m10, q);
         end
      endcase
      return res;
   endfunction

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      quat_type want, got;
      if (!reset) begin
         if (start && !busy)
            quat_queue.push_back(matrix_to_quat(a00, a01, a02, a10, a11, a12,
                                                a20, a21, a22));
         if (rsp_valid) begin
            got = {quat_x, quat_y, quat_z, quat_w};
            if (quat_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected beat: %p", got);
            end else begin
               want = quat_queue.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected x=%0d y=%0d z=%0d w=%0d",
                               " got x=%0d y=%0d z=%0d w=%0d"},
                              want.x, want.y, want.z, want.w,
                              got.x, got.y, got.z, got.w);
               end
            end
         end
      end
      pending = quat_queue.size();
   end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
   import qfrm_pkg::*;

   localparam int N_RANDOM = 930;
   localparam int LATENCY  = 31;
   localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1 <<< FRAC_BITS);

   typedef logic signed [DATA_WIDTH-1:0] elem_type;

   logic  clock = 0, reset = 1, start = 0, busy, rsp_valid;
   elem_type m [9];
   elem_type quat_x, quat_y, quat_z, quat_w;
   int    fail_count, pending;

   initial for (int i = 0; i < 9; i++) m[i] = '0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   quaternion_from_rotation_matrix_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a00(m[0]), .req_a01(m[1]), .req_a02(m[2]),
      .req_a10(m[3]), .req_a11(m[4]), .req_a12(m[5]),
      .req_a20(m[6]), .req_a21(m[7]), .req_a22(m[8]),
      .rsp_valid(rsp_valid),
      .rsp_quat_x(quat_x), .rsp_quat_y(quat_y), .rsp_quat_z(quat_z), .rsp_quat_w(quat_w));

   qfrm_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .a00(m[0]), .a01(m[1]), .a02(m[2]), .a10(m[3]), .a11(m[4]), .a12(m[5]),
      .a20(m[6]), .a21(m[7]), .a22(m[8]),
      .rsp_valid(rsp_valid), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
      .quat_w(quat_w), .fail_count(fail_count), .pending(pending));

   int burst_left = 0;

   // present one beat, with a random gap once the current burst runs out
   task automatic send_matrix(input elem_type v [9]);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      foreach (v[i]) m[i] <= v[i];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
   endtask

   function automatic elem_type near_rot(input int base);
      return elem_type'(base + $signed($urandom_range(0, 64)) - 32);
   endfunction

   initial begin
      elem_type v [9];
      int    mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity, half turns about each axis (one per pick), extremes, ties
      v = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};           send_matrix(v);
      v = '{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q};         send_matrix(v);
      v = '{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q};         send_matrix(v);
      v = '{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q};         send_matrix(v);
      v = '{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q};          send_matrix(v);
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(v);
      foreach (v[i]) v[i] = 16'sh7fff;                        send_matrix(v);
      foreach (v[i]) v[i] = 16'sh8000;                        send_matrix(v);
      v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
            16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};      send_matrix(v);
      v = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};      send_matrix(v);
      v = '{0, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, 16'sh7fff,
            16'sh8000, 16'sh8000, 0};                         send_matrix(v);
      v = '{16'sh4000, 5, -7, 3, 16'sh4000, 9, -2, 4, -16'sh4000}; send_matrix(v);
      v = '{-16'sh2000, 1, 2, 3, -16'sh2000, 4, 5, 6, -16'sh2000}; send_matrix(v);
      v = '{-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000,
            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};      send_matrix(v);

      for (int n = 0; n < N_RANDOM; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 5) begin
            // near a signed permutation matrix, so every pick shows up
            int axis, sgn;
            axis = $urandom_range(0, 3);
            foreach (v[i]) v[i] = near_rot(0);
            for (int d = 0; d < 3; d++) begin
               sgn = (axis == 0 || axis == d + 1) ? 1 : -1;
               v[d * 4] = near_rot(sgn * ONE_Q);
            end
         end else if (mode < 8) begin
            foreach (v[i]) v[i] = elem_type'($urandom);
         end else begin
            foreach (v[i]) v[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         end
         send_matrix(v);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
